### sv/taxel_spiking_neuron_array_assert.svh
// assertion macros for the taxel spiking neuron array
// expects signals named clock and reset in the module that includes it
`ifndef TAXEL_SPIKING_NEURON_ARRAY_ASSERT_SVH
`define TAXEL_SPIKING_NEURON_ARRAY_ASSERT_SVH

// same-cycle implication
`define TSNA_ASSERT_IMP(label, cond, expr, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |-> (expr)) \
      else $error(msg);

// next-cycle implication
`define TSNA_ASSERT_NXT(label, cond, expr, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |=> (expr)) \
      else $error(msg);

`endif

### sv/tsna_pkg.sv
// shared constants, types and helpers for the taxel spiking neuron array
// no dependencies
`timescale 1ns / 1ps

package tsna_pkg;

   localparam int TAXEL_COUNT  = 16;
   localparam int LANES        = 4;
   localparam int COLUMN_COUNT = TAXEL_COUNT / LANES;
   localparam int COLUMN_W     = $clog2(COLUMN_COUNT);
   localparam int SAMPLE_W     = 12;
   localparam int MASK_W       = 4;
   localparam int CSR_INDEX_W  = 3;
   localparam int CSR_DATA_W   = 24;

   // register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_RECOVERY_RATE        = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_RECOVERY_SENSITIVITY = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_RESET_POTENTIAL      = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_RECOVERY_INCREMENT   = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_SPIKE_THRESHOLD      = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_CURRENT_GAIN         = 3'd5;

   // register reset values
   localparam logic [15:0]        RST_RECOVERY_RATE        = 16'd1311;
   localparam logic [15:0]        RST_RECOVERY_SENSITIVITY = 16'd13107;
   localparam logic signed [23:0] RST_RESET_POTENTIAL      = -24'sd4259840;
   localparam logic [21:0]        RST_RECOVERY_INCREMENT   = 22'd524288;
   localparam logic [23:0]        RST_SPIKE_THRESHOLD      = 24'd1966080;
   localparam logic [15:0]        RST_CURRENT_GAIN         = 16'd293;

   // per-taxel state after reset
   localparam logic [SAMPLE_W-1:0] RST_PREV_SAMPLE = 12'd4095;
   localparam logic signed [31:0]  RST_POTENTIAL   = -32'sd1966080;
   localparam logic signed [31:0]  RST_RECOVERY    = 32'sd0;

   // 0.04 in q0.16, linear term and 140 in q16.16
   localparam logic [11:0] QUAD_COEF   = 12'd2621;
   localparam int          LINEAR_COEF = 5;
   localparam int          OFFSET_Q16  = 140 * 65536;

   typedef struct packed {
      logic [15:0]        recovery_rate;
      logic [15:0]        recovery_sensitivity;
      logic signed [23:0] reset_potential;
      logic [21:0]        recovery_increment;
      logic [23:0]        spike_threshold;
      logic [15:0]        current_gain;
   } cfg_type;

   // stage enables shared by the lanes, the control and the output stage
   typedef struct packed {
      logic                load;
      logic                s2_en;
      logic                s3_en;
      logic                wb;
      logic [COLUMN_W-1:0] wb_column;
   } pipe_ctl_type;

   typedef struct packed {
      logic [2:0]          valid;
      logic [COLUMN_W-1:0] col1;
      logic [COLUMN_W-1:0] col2;
      logic [COLUMN_W-1:0] col3;
   } pipe_stat_type;

   function automatic logic signed [31:0] sat32(input logic signed [47:0] x);
      logic signed [31:0] r;
      if (x > 48'sh0000_7FFF_FFFF) begin
         r = 32'sh7FFF_FFFF;
      end else if (x < 48'shFFFF_8000_0000) begin
         r = 32'sh8000_0000;
      end else begin
         r = x[31:0];
      end
      return r;
   endfunction

endpackage

### sv/tsna_ctrl.sv
// pipeline control: stage valids, column tags and same-column hold-off
// depends on tsna_pkg
`timescale 1ns / 1ps

module tsna_ctrl (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   input  logic [tsna_pkg::COLUMN_W-1:0] req_column,
   input  logic                          out_ready,
   output logic                          req_stall,
   output tsna_pkg::pipe_ctl_type        ctl,
   output tsna_pkg::pipe_stat_type       stat
);
   import tsna_pkg::*;

   logic [2:0]          valid_ff;
   logic [2:0]          valid_in;
   logic [COLUMN_W-1:0] col1_ff, col2_ff, col3_ff;
   logic                m1, m2, m3;
   logic                free1, free2, free3;
   logic                hazard;
   logic                accept;

   // a stage moves on when the next one is empty or moving
   assign m3    = valid_ff[2] && out_ready;
   assign free3 = !valid_ff[2] || m3;
   assign m2    = valid_ff[1] && free3;
   assign free2 = !valid_ff[1] || m2;
   assign m1    = valid_ff[0] && free2;
   assign free1 = !valid_ff[0] || m1;

   // state of a column in flight is not written back yet
   assign hazard = (valid_ff[0] && (col1_ff == req_column)) ||
                   (valid_ff[1] && (col2_ff == req_column)) ||
                   (valid_ff[2] && (col3_ff == req_column));

   assign req_stall = !free1 || hazard;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      valid_in[0] = accept || (valid_ff[0] && !m1);
      valid_in[1] = m1 || (valid_ff[1] && !m2);
      valid_in[2] = m2 || (valid_ff[2] && !m3);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         col1_ff <= req_column;
      end
      if (m1) begin
         col2_ff <= col1_ff;
      end
      if (m2) begin
         col3_ff <= col2_ff;
      end
   end

   assign ctl.load      = accept;
   assign ctl.s2_en     = m1;
   assign ctl.s3_en     = m2;
   assign ctl.wb        = m3;
   assign ctl.wb_column = col3_ff;

   assign stat.valid = valid_ff;
   assign stat.col1  = col1_ff;
   assign stat.col2  = col2_ff;
   assign stat.col3  = col3_ff;

endmodule

### sv/tsna_lane.sv
// one row lane: taxel state bank for its row and the three-stage euler step
// depends on tsna_pkg
`timescale 1ns / 1ps

module tsna_lane (
   input  logic                          clock,
   input  logic                          reset,
   input  tsna_pkg::pipe_ctl_type        ctl,
   input  logic [tsna_pkg::COLUMN_W-1:0] req_column,
   input  logic [tsna_pkg::SAMPLE_W-1:0] sample,
   input  tsna_pkg::cfg_type             cfg,
   output logic                          spike
);
   import tsna_pkg::*;

   // state bank, one entry per column
   logic [SAMPLE_W-1:0] prev_ff   [COLUMN_COUNT];
   logic signed [31:0]  v_bank_ff [COLUMN_COUNT];
   logic signed [31:0]  u_bank_ff [COLUMN_COUNT];

   // stage 1: sample difference and state read
   logic signed [SAMPLE_W:0] diff_in, diff_ff;
   logic signed [31:0]       v1_in, v1_ff, u1_in, u1_ff;

   // stage 2: first products
   logic signed [63:0] vv;
   logic signed [48:0] bv_full;
   logic signed [29:0] cur_full;
   logic [46:0]        vsq_in, vsq_ff;
   logic signed [32:0] bv_in, bv_ff;
   logic signed [29:0] cur2_ff;
   logic signed [31:0] v2_ff, u2_ff;

   // stage 3: second products
   logic [58:0]        q_full;
   logic signed [33:0] rd;
   logic signed [50:0] du_full;
   logic [42:0]        q_in, q_ff;
   logic signed [34:0] du_in, du_ff;
   logic signed [29:0] cur3_ff;
   logic signed [31:0] v3_ff, u3_ff;

   // final sums, saturation and spike test
   logic signed [45:0] dv;
   logic signed [47:0] vn, un;
   logic signed [31:0] v_sat, u_sat, u_spk;
   logic signed [31:0] v_wr_in, u_wr_in;

   assign diff_in = $signed({1'b0, sample}) - $signed({1'b0, prev_ff[req_column]});
   assign v1_in   = v_bank_ff[req_column];
   assign u1_in   = u_bank_ff[req_column];

   always_ff @(posedge clock) begin
      if (ctl.load) begin
         diff_ff <= diff_in;
         v1_ff   <= v1_in;
         u1_ff   <= u1_in;
      end
   end

   assign vv       = v1_ff * v1_ff;
   assign bv_full  = $signed({1'b0, cfg.recovery_sensitivity}) * v1_ff;
   assign cur_full = $signed({1'b0, cfg.current_gain}) * diff_ff;
   assign vsq_in   = vv[62:16];
   assign bv_in    = bv_full[48:16];

   always_ff @(posedge clock) begin
      if (ctl.s2_en) begin
         vsq_ff  <= vsq_in;
         bv_ff   <= bv_in;
         cur2_ff <= cur_full;
         v2_ff   <= v1_ff;
         u2_ff   <= u1_ff;
      end
   end

   assign q_full  = vsq_ff * QUAD_COEF;
   assign rd      = 34'(bv_ff) - 34'(u2_ff);
   assign du_full = $signed({1'b0, cfg.recovery_rate}) * rd;
   assign q_in    = q_full[58:16];
   assign du_in   = du_full[50:16];

   always_ff @(posedge clock) begin
      if (ctl.s3_en) begin
         q_ff    <= q_in;
         du_ff   <= du_in;
         cur3_ff <= cur2_ff;
         v3_ff   <= v2_ff;
         u3_ff   <= u2_ff;
      end
   end

   assign dv = 46'($signed({1'b0, q_ff})) + 46'(v3_ff) * 46'(LINEAR_COEF)
             + 46'(OFFSET_Q16) - 46'(u3_ff) + 46'(cur3_ff);
   assign vn = 48'(v3_ff) + 48'($signed({dv, 1'b0}));
   assign un = 48'(u3_ff) + 48'($signed({du_ff, 1'b0}));

   assign v_sat = sat32(vn);
   assign u_sat = sat32(un);
   assign spike = $signed({v_sat[31], v_sat}) >= $signed({9'd0, cfg.spike_threshold});
   assign u_spk = sat32(48'(u_sat) + 48'($signed({1'b0, cfg.recovery_increment})));

   assign v_wr_in = spike ? 32'($signed(cfg.reset_potential)) : v_sat;
   assign u_wr_in = spike ? u_spk : u_sat;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < COLUMN_COUNT; i++) begin
            prev_ff[i]   <= RST_PREV_SAMPLE;
            v_bank_ff[i] <= RST_POTENTIAL;
            u_bank_ff[i] <= RST_RECOVERY;
         end
      end else begin
         if (ctl.load) begin
            prev_ff[req_column] <= sample;
         end
         if (ctl.wb) begin
            v_bank_ff[ctl.wb_column] <= v_wr_in;
            u_bank_ff[ctl.wb_column] <= u_wr_in;
         end
      end
   end

endmodule

### sv/tsna_merge.sv
// output stage: gathers the lane spike bits into the column mask and holds it
// depends on tsna_pkg
`timescale 1ns / 1ps

module tsna_merge (
   input  logic                          clock,
   input  logic                          reset,
   input  tsna_pkg::pipe_ctl_type        ctl,
   input  logic [tsna_pkg::LANES-1:0]    spikes,
   input  logic                          rsp_stall,
   output logic                          rsp_valid,
   output logic [tsna_pkg::COLUMN_W-1:0] rsp_column_out,
   output logic [tsna_pkg::MASK_W-1:0]   rsp_spike_mask,
   output logic                          out_ready
);
   import tsna_pkg::*;

   logic                valid_ff, valid_in;
   logic [COLUMN_W-1:0] column_ff;
   logic [MASK_W-1:0]   mask_ff, mask_in;

   assign out_ready = !valid_ff || !rsp_stall;
   assign valid_in  = ctl.wb || (valid_ff && rsp_stall);
   assign mask_in   = MASK_W'(spikes);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.wb) begin
         column_ff <= ctl.wb_column;
         mask_ff   <= mask_in;
      end
   end

   assign rsp_valid      = valid_ff;
   assign rsp_column_out = column_ff;
   assign rsp_spike_mask = mask_ff;

endmodule

### sv/taxel_spiking_neuron_array.sv
// top level of the taxel spiking neuron array: register file, lanes, control
// depends on tsna_pkg, tsna_ctrl, tsna_lane, tsna_merge and the assertion header
`timescale 1ns / 1ps

// usage
// - req channel carries one scanned column: the column number and the four
//   row samples; a transfer happens when req_valid is high and req_stall low
// - each row lane updates the izhikevich neuron of taxel (column, row) by one
//   euler step and the rsp channel returns the column with its spike mask
// - csr channel writes the six neuron registers; csr_ready is always high,
//   writes are meant for idle periods only, unknown indexes are dropped
// - pipeline: a result passes two multiplier stages plus the writeback/output
//   stage after its request transfer before it shows up on rsp_valid
// - throughput: one column per cycle as long as a column does not repeat
//   within the three requests before it and rsp_stall does not fill the pipe;
//   a repeated column waits until the earlier update has written its state back
// - reset: every taxel returns to previous sample 4095, potential -30.0,
//   recovery 0; the registers take their default values; the pipe empties
// - rsp_stall holds the result register; the three inner stages keep taking
//   new columns until they are full, then req_stall goes high

module taxel_spiking_neuron_array (
   input  logic                             clock,
   input  logic                             reset,
   // request channel
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic [tsna_pkg::COLUMN_W-1:0]    req_column,
   input  logic [tsna_pkg::SAMPLE_W-1:0]    req_sample_row0,
   input  logic [tsna_pkg::SAMPLE_W-1:0]    req_sample_row1,
   input  logic [tsna_pkg::SAMPLE_W-1:0]    req_sample_row2,
   input  logic [tsna_pkg::SAMPLE_W-1:0]    req_sample_row3,
   // response channel
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic [tsna_pkg::COLUMN_W-1:0]    rsp_column_out,
   output logic [tsna_pkg::MASK_W-1:0]      rsp_spike_mask,
   // register write channel
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [tsna_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [tsna_pkg::CSR_DATA_W-1:0]  csr_data
);
   import tsna_pkg::*;

   cfg_type             cfg_ff, cfg_in;
   pipe_ctl_type        ctl;
   pipe_stat_type       stat;
   logic                out_ready;
   logic [SAMPLE_W-1:0] samples [LANES];
   logic [LANES-1:0]    spikes;

   // register file; writing only while the array is idle is left to the user
   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_RECOVERY_RATE:        cfg_in.recovery_rate        = csr_data[15:0];
            CSR_RECOVERY_SENSITIVITY: cfg_in.recovery_sensitivity = csr_data[15:0];
            CSR_RESET_POTENTIAL:      cfg_in.reset_potential      = $signed(csr_data[23:0]);
            CSR_RECOVERY_INCREMENT:   cfg_in.recovery_increment   = csr_data[21:0];
            CSR_SPIKE_THRESHOLD:      cfg_in.spike_threshold      = csr_data[23:0];
            CSR_CURRENT_GAIN:         cfg_in.current_gain         = csr_data[15:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.recovery_rate        <= RST_RECOVERY_RATE;
         cfg_ff.recovery_sensitivity <= RST_RECOVERY_SENSITIVITY;
         cfg_ff.reset_potential      <= RST_RESET_POTENTIAL;
         cfg_ff.recovery_increment   <= RST_RECOVERY_INCREMENT;
         cfg_ff.spike_threshold      <= RST_SPIKE_THRESHOLD;
         cfg_ff.current_gain         <= RST_CURRENT_GAIN;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // stage valids, column tags and the same-column hold-off
   tsna_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_column (req_column),
      .out_ready  (out_ready),
      .req_stall  (req_stall),
      .ctl        (ctl),
      .stat       (stat)
   );

   // row r sample feeds lane r
   assign samples[0] = req_sample_row0;
   assign samples[1] = req_sample_row1;
   assign samples[2] = req_sample_row2;
   assign samples[3] = req_sample_row3;

   for (genvar r = 0; r < LANES; r++) begin : g_lane
      tsna_lane u_lane (
         .clock      (clock),
         .reset      (reset),
         .ctl        (ctl),
         .req_column (req_column),
         .sample     (samples[r]),
         .cfg        (cfg_ff),
         .spike      (spikes[r])
      );
   end

   // lane spikes become the column mask in the result register
   tsna_merge u_merge (
      .clock          (clock),
      .reset          (reset),
      .ctl            (ctl),
      .spikes         (spikes),
      .rsp_stall      (rsp_stall),
      .rsp_valid      (rsp_valid),
      .rsp_column_out (rsp_column_out),
      .rsp_spike_mask (rsp_spike_mask),
      .out_ready      (out_ready)
   );

   // columns in flight never repeat, else a lane would read stale state
   `include "taxel_spiking_neuron_array_assert.svh"

   `TSNA_ASSERT_IMP(a_cols_near, stat.valid[0] && stat.valid[1], (stat.col1 != stat.col2) && (!stat.valid[2] || (stat.col2 != stat.col3)), "column repeated in adjacent stages")
   `TSNA_ASSERT_IMP(a_cols_far, stat.valid[0] && stat.valid[2], stat.col1 != stat.col3, "column repeated in first and last stage")
   `TSNA_ASSERT_NXT(a_wb_shows, ctl.wb, rsp_valid, "writeback without a result")
   `TSNA_ASSERT_IMP(a_rst_empty, $past(reset), !rsp_valid && (stat.valid == 3'b000), "pipe not empty after reset")

endmodule

### dv/taxel_spiking_neuron_array_test.sv
// self-checking testbench for taxel_spiking_neuron_array: directed column scans, then
// random scans under several register settings, checked against a fixed-point neuron model
// depends on tsna_pkg and the taxel_spiking_neuron_array rtl
`timescale 1ns / 1ps

module taxel_spiking_neuron_array_test;

   localparam int          CYCLE_LIMIT   = 300000;
   localparam int          SETTLE_CYCLES = 8;
   localparam int          DRAIN_LIMIT   = 5000;
   localparam int          REPORT_LIMIT  = 10;
   localparam int          PHASE_ITEMS   = 330;
   localparam int          PHASE_COUNT   = 6;
   localparam int          SCRIPT_ROWS   = 18;

   // indexes past the last register, writes there must be dropped
   localparam logic [tsna_pkg::CSR_INDEX_W-1:0] CSR_SPARE_LOW  = 3'd6;
   localparam logic [tsna_pkg::CSR_INDEX_W-1:0] CSR_SPARE_HIGH = 3'd7;

   // neuron constants in q16.16 / q0.16
   localparam longint SQUARE_COEF     = 2621;           // 0.04
   localparam longint POTENTIAL_SLOPE = 5;
   localparam longint RESTING_DRIVE   = 140 * 65536;
   localparam longint SAT_HI          = 64'sh0000_0000_7FFF_FFFF;
   localparam longint SAT_LO          = 64'shFFFF_FFFF_8000_0000;

   // taxel state and register values after reset
   localparam logic [11:0] INIT_SAMPLE    = 12'd4095;
   localparam int          INIT_POTENTIAL = -1966080;   // -30.0
   localparam int          INIT_RECOVERY  = 0;
   localparam int          DEF_RATE       = 1311;
   localparam int          DEF_SENS       = 13107;
   localparam int          DEF_RESET_POT  = -4259840;   // -65.0
   localparam int          DEF_INCREMENT  = 524288;     // 8.0
   localparam int          DEF_THRESHOLD  = 1966080;    // 30.0
   localparam int          DEF_GAIN       = 293;

   typedef struct packed {
      logic [1:0] column;
      logic [3:0] mask;
   } column_result_type;

   // one directed column scan; mask is typed in only where known is set
   typedef struct packed {
      logic [1:0]  column;
      logic [11:0] row0;
      logic [11:0] row1;
      logic [11:0] row2;
      logic [11:0] row3;
      logic        known;
      logic [3:0]  mask;
   } scan_row_type;

   // the first rows run on fresh taxels with default registers: an unchanged sample
   // lifts v from -30 to about 22 and a full-scale drop only to about -14.6, no spike;
   // later rows hit the same columns back to back, swing between the sample extremes
   // and walk single bits, their masks come from the model
   localparam scan_row_type SCAN_SCRIPT [SCRIPT_ROWS] = '{
      '{2'd0, 12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF, 1'b1, 4'b0000},
      '{2'd1, 12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF, 1'b1, 4'b0000},
      '{2'd2, 12'h000, 12'h000, 12'h000, 12'h000, 1'b1, 4'b0000},
      '{2'd3, 12'hAAA, 12'h555, 12'hFFF, 12'h000, 1'b0, 4'b0000},
      '{2'd0, 12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF, 1'b0, 4'b0000},
      '{2'd0, 12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF, 1'b0, 4'b0000},
      '{2'd0, 12'h000, 12'hFFF, 12'h000, 12'hFFF, 1'b0, 4'b0000},
      '{2'd2, 12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF, 1'b0, 4'b0000},
      '{2'd2, 12'h000, 12'h000, 12'h000, 12'h000, 1'b0, 4'b0000},
      '{2'd1, 12'h000, 12'hFFF, 12'h000, 12'hFFF, 1'b0, 4'b0000},
      '{2'd1, 12'hFFF, 12'h000, 12'hFFF, 12'h000, 1'b0, 4'b0000},
      '{2'd3, 12'h555, 12'hAAA, 12'h000, 12'hFFF, 1'b0, 4'b0000},
      '{2'd3, 12'h001, 12'h800, 12'h7FF, 12'hFFE, 1'b0, 4'b0000},
      '{2'd3, 12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF, 1'b0, 4'b0000},
      '{2'd0, 12'h001, 12'h002, 12'h004, 12'h008, 1'b0, 4'b0000},
      '{2'd1, 12'h010, 12'h020, 12'h040, 12'h080, 1'b0, 4'b0000},
      '{2'd2, 12'h100, 12'h200, 12'h400, 12'h800, 1'b0, 4'b0000},
      '{2'd3, 12'hFFF, 12'h000, 12'h000, 12'hFFF, 1'b0, 4'b0000}
   };

   logic                             clock = 1'b0;
   logic                             reset;
   logic                             req_valid;
   logic                             req_stall;
   logic [tsna_pkg::COLUMN_W-1:0]    req_column;
   logic [tsna_pkg::SAMPLE_W-1:0]    req_sample_row0;
   logic [tsna_pkg::SAMPLE_W-1:0]    req_sample_row1;
   logic [tsna_pkg::SAMPLE_W-1:0]    req_sample_row2;
   logic [tsna_pkg::SAMPLE_W-1:0]    req_sample_row3;
   logic                             rsp_valid;
   logic                             rsp_stall;
   logic [tsna_pkg::COLUMN_W-1:0]    rsp_column_out;
   logic [tsna_pkg::MASK_W-1:0]      rsp_spike_mask;
   logic                             csr_valid;
   logic                             csr_ready;
   logic [tsna_pkg::CSR_INDEX_W-1:0] csr_index;
   logic [tsna_pkg::CSR_DATA_W-1:0]  csr_data;

   // model copy of the taxel grid and the registers
   logic [11:0] last_sample [tsna_pkg::TAXEL_COUNT];
   int          potential   [tsna_pkg::TAXEL_COUNT];
   int          recovery    [tsna_pkg::TAXEL_COUNT];
   longint      rate_a;
   longint      sens_b;
   longint      reset_c;
   longint      incr_d;
   longint      threshold;
   longint      gain;

   column_result_type expected_results [$];
   int unsigned    fault_count   = 0;
   int unsigned    cycle_count   = 0;
   int unsigned    send_idle_pct = 0;
   int unsigned    stall_pct     = 0;
   logic [1:0]     last_column   = 2'd0;

   taxel_spiking_neuron_array uut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_column      (req_column),
      .req_sample_row0 (req_sample_row0),
      .req_sample_row1 (req_sample_row1),
      .req_sample_row2 (req_sample_row2),
      .req_sample_row3 (req_sample_row3),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_column_out  (rsp_column_out),
      .rsp_spike_mask  (rsp_spike_mask),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_data        (csr_data)
   );

   always #1 clock = ~clock;

   // run limit, far beyond the slowest legal run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("taxel_spiking_neuron_array: mismatch");
         $finish;
      end
   end

   function automatic int clamp_q16(input longint x);
      if (x > SAT_HI) begin
         return int'(SAT_HI);
      end
      if (x < SAT_LO) begin
         return int'(SAT_LO);
      end
      return int'(x);
   endfunction

   // one euler step (dt 2) for the four taxels of a column, returns the spike mask
   function automatic logic [3:0] advance_taxels(input logic [1:0] col,
                                                 input logic [3:0][11:0] smp);
      logic [3:0] mask;
      int         idx;
      longint     v, u, cur, vsq, dv, du;
      int         nv, nu;
      mask = 4'b0000;
      for (int r = 0; r < tsna_pkg::LANES; r++) begin
         idx = int'(col) * tsna_pkg::LANES + r;
         // lanes past the end of the grid stay untouched and never spike
         if (idx < tsna_pkg::TAXEL_COUNT) begin
            cur = gain * (longint'(smp[r]) - longint'(last_sample[idx]));
            last_sample[idx] = smp[r];
            v = longint'(potential[idx]);
            u = longint'(recovery[idx]);
            // every product floors toward minus infinity
            vsq = (v * v) >>> 16;
            dv = ((vsq * SQUARE_COEF) >>> 16) + POTENTIAL_SLOPE * v + RESTING_DRIVE - u + cur;
            du = (rate_a * (((sens_b * v) >>> 16) - u)) >>> 16;
            nv = clamp_q16(v + 2 * dv);
            nu = clamp_q16(u + 2 * du);
            if (longint'(nv) >= threshold) begin
               nv = int'(reset_c);
               nu = clamp_q16(longint'(nu) + incr_d);
               mask[r] = 1'b1;
            end
            potential[idx] = nv;
            recovery[idx] = nu;
         end
      end
      return mask;
   endfunction

   // one register write transfer; valid stays high for a following write
   task automatic write_reg(input logic [tsna_pkg::CSR_INDEX_W-1:0] index,
                            input logic [tsna_pkg::CSR_DATA_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data <= data;
      @(posedge clock);
      while (!csr_ready) begin
         @(posedge clock);
      end
      case (index)
         tsna_pkg::CSR_RECOVERY_RATE:        rate_a = longint'(data[15:0]);
         tsna_pkg::CSR_RECOVERY_SENSITIVITY: sens_b = longint'(data[15:0]);
         tsna_pkg::CSR_RESET_POTENTIAL:      reset_c = longint'($signed(data[23:0]));
         tsna_pkg::CSR_RECOVERY_INCREMENT:   incr_d = longint'(data[21:0]);
         tsna_pkg::CSR_SPIKE_THRESHOLD:      threshold = longint'(data[23:0]);
         tsna_pkg::CSR_CURRENT_GAIN:         gain = longint'(data[15:0]);
         default: ;  // unknown index, dropped
      endcase
   endtask

   // stop sending and let every outstanding result come back
   task automatic settle_pipeline();
      req_valid <= 1'b0;
      for (int n = 0; expected_results.size() != 0 && n < DRAIN_LIMIT; n++) begin
         @(posedge clock);
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // registers change only with the pipe empty
   task automatic load_settings(input logic [15:0] a, input logic [15:0] b,
                                input logic [23:0] c, input logic [21:0] d,
                                input logic [23:0] thr, input logic [15:0] g);
      settle_pipeline();
      write_reg(tsna_pkg::CSR_RECOVERY_RATE, {8'h00, a});
      write_reg(tsna_pkg::CSR_RECOVERY_SENSITIVITY, {8'h00, b});
      write_reg(tsna_pkg::CSR_RESET_POTENTIAL, c);
      write_reg(tsna_pkg::CSR_RECOVERY_INCREMENT, {2'b00, d});
      write_reg(tsna_pkg::CSR_SPIKE_THRESHOLD, thr);
      write_reg(tsna_pkg::CSR_CURRENT_GAIN, {8'h00, g});
      csr_valid <= 1'b0;
   endtask

   // offer one column, hold it until the transfer, then log what it should produce
   task automatic transfer_column(input logic [1:0] col, input logic [3:0][11:0] smp,
                                  input logic known, input logic [3:0] known_mask);
      logic [3:0]        mask;
      column_result_type want;
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_column <= col;
      req_sample_row0 <= smp[0];
      req_sample_row1 <= smp[1];
      req_sample_row2 <= smp[2];
      req_sample_row3 <= smp[3];
      @(posedge clock);
      while (req_stall) begin
         @(posedge clock);
      end
      mask = advance_taxels(col, smp);
      want.column = col;
      want.mask = known ? known_mask : mask;
      expected_results.push_back(want);
      last_column = col;
   endtask

   // mostly slow drifts around the last sample, with full-scale jumps and noise
   task automatic send_random_column();
      logic [1:0]       col;
      logic [3:0][11:0] smp;
      int               t;
      case ($urandom_range(0, 3))
         0:       col = last_column;                  // same column again, hazard path
         1:       col = 2'($urandom_range(0, 3));
         default: col = last_column + 2'd1;           // plain scan order
      endcase
      for (int r = 0; r < 4; r++) begin
         case ($urandom_range(0, 9))
            0:       smp[r] = 12'h000;
            1:       smp[r] = 12'hFFF;
            2, 3:    smp[r] = 12'($urandom_range(0, 4095));
            default: begin
               t = int'(last_sample[int'(col) * tsna_pkg::LANES + r]) +
                   int'($urandom_range(0, 300)) - 100;
               if (t < 0) begin
                  t = 0;
               end
               if (t > 4095) begin
                  t = 4095;
               end
               smp[r] = 12'(t);
            end
         endcase
      end
      transfer_column(col, smp, 1'b0, 4'b0000);
   endtask

   task automatic check_result();
      column_result_type want;
      if (expected_results.size() == 0) begin
         if (fault_count < REPORT_LIMIT) begin
            $display("unexpected result: column %0d spike mask %b",
                     rsp_column_out, rsp_spike_mask);
         end
         fault_count++;
      end else begin
         want = expected_results.pop_front();
         if (rsp_column_out !== want.column || rsp_spike_mask !== want.mask) begin
            if (fault_count < REPORT_LIMIT) begin
               $display("bad result: column exp %0d got %0d, spike mask exp %b got %b",
                        want.column, rsp_column_out, want.mask, rsp_spike_mask);
            end
            fault_count++;
         end
      end
   endtask

   // receiver: check each result transfer, stall at random
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            check_result();
         end
         rsp_stall <= ($urandom_range(0, 99) < stall_pct);
      end
   end

   initial begin
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_column <= '0;
      req_sample_row0 <= '0;
      req_sample_row1 <= '0;
      req_sample_row2 <= '0;
      req_sample_row3 <= '0;
      csr_valid <= 1'b0;
      csr_index <= '0;
      csr_data <= '0;

      // model state after reset
      for (int i = 0; i < tsna_pkg::TAXEL_COUNT; i++) begin
         last_sample[i] = INIT_SAMPLE;
         potential[i] = INIT_POTENTIAL;
         recovery[i] = INIT_RECOVERY;
      end
      rate_a = longint'(DEF_RATE);
      sens_b = longint'(DEF_SENS);
      reset_c = longint'(DEF_RESET_POT);
      incr_d = longint'(DEF_INCREMENT);
      threshold = longint'(DEF_THRESHOLD);
      gain = longint'(DEF_GAIN);

      // sender rarely idle, receiver mostly stalled
      send_idle_pct = 12;
      stall_pct = 73;

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // junk to the spare indexes first: the default-register rows below
      // would show it if either write landed in a real register
      write_reg(CSR_SPARE_LOW, 24'($urandom_range(0, 24'hFFFFFF)));
      write_reg(CSR_SPARE_HIGH, 24'($urandom_range(0, 24'hFFFFFF)));
      csr_valid <= 1'b0;

      foreach (SCAN_SCRIPT[i]) begin
         transfer_column(SCAN_SCRIPT[i].column,
                         {SCAN_SCRIPT[i].row3, SCAN_SCRIPT[i].row2,
                          SCAN_SCRIPT[i].row1, SCAN_SCRIPT[i].row0},
                         SCAN_SCRIPT[i].known, SCAN_SCRIPT[i].mask);
      end

      for (int p = 0; p < PHASE_COUNT; p++) begin
         // idle pattern: sender light / receiver heavy, then swapped, then none
         if (p < 2) begin
            send_idle_pct = 12;
            stall_pct = 73;
         end else if (p < 4) begin
            send_idle_pct = 73;
            stall_pct = 12;
         end else begin
            send_idle_pct = 0;
            stall_pct = 0;
         end
         case (p)
            // low corner: no recovery, no input current, spike at zero, reset to -128
            1: load_settings(16'd0, 16'd0, 24'h800000, 22'd0, 24'd0, 16'd0);
            // high corner: full gain drives v into saturation
            2: load_settings(16'hFFFF, 16'hFFFF, 24'd0, 22'd2097152, 24'd8388608, 16'hFFFF);
            3, 4: load_settings(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                                24'(-int'($urandom_range(0, 8388608))),
                                22'($urandom_range(0, 2097152)),
                                24'($urandom_range(0, 8388608)), 16'($urandom_range(0, 65535)));
            // back to the power-on values, written explicitly
            5: load_settings(16'(DEF_RATE), 16'(DEF_SENS), 24'(DEF_RESET_POT),
                             22'(DEF_INCREMENT), 24'(DEF_THRESHOLD), 16'(DEF_GAIN));
            default: ;  // defaults straight after the directed scans
         endcase
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            send_random_column();
         end
      end

      settle_pipeline();
      fault_count += expected_results.size();
      if (fault_count == 0) begin
         $display("taxel_spiking_neuron_array: match");
      end else begin
         $display("taxel_spiking_neuron_array: mismatch");
      end
      $finish;
   end

endmodule
